/* hw/rtl/rbag_pkg.sv */
// Package for the ROM bank address generator.
// Operation codes, register indexes, bank rule codes and the bank state type.
// No dependencies.
package rbag_pkg;

  typedef enum logic [2:0] {
    OP_BANK1_WR = 3'd0,
    OP_BANK2_WR = 3'd1,
    OP_GFXBK_WR = 3'd2,
    OP_ADRLO_WR = 3'd3,
    OP_ADRHI_WR = 3'd4,
    OP_COIN_WR  = 3'd5,
    OP_SND_RD   = 3'd6,
    OP_GFX_RD   = 3'd7
  } op_e;

  // configuration register indexes
  localparam logic [1:0] CfgSndMode   = 2'd0;
  localparam logic [1:0] CfgSndBytes  = 2'd1;
  localparam logic [1:0] CfgCoinTog   = 2'd2;

  // sound bank rules
  localparam logic [2:0] ModeBank2Bit0 = 3'd0;
  localparam logic [2:0] ModeBit0      = 3'd1;
  localparam logic [2:0] ModeFull      = 3'd2;
  localparam logic [2:0] ModeSwapHalf  = 3'd3;
  localparam logic [2:0] ModeHalf      = 3'd4;

  localparam logic [2:0]  SndModeRst  = ModeHalf;
  localparam logic [18:0] SndBytesRst = 19'h40000;

  typedef struct packed {
    logic [2:0] snd_bank_lo;
    logic [1:0] snd_bank_hi;
    logic [3:0] gfx_bank;
    logic [7:0] gfx_adr_lo;
    logic [7:0] gfx_adr_hi;
    logic       nmi_en;
    logic       coin_flag;
  } bank_state_t;

endpackage

/* hw/rtl/rbag_bank_regs.sv */
// Bank, address byte, NMI enable and coin-out flag registers.
// Updated on each transfer of a write operation. Depends on rbag_pkg.
module rbag_bank_regs import rbag_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  op_e         op_i,
  input  logic [7:0]  data_i,
  input  logic        coin_tog_i,
  output bank_state_t state_o,
  output bank_state_t state_nxt_o
);

  // everything clear except the coin-out flag
  localparam bank_state_t StateRst = '{coin_flag: 1'b1, default: '0};

  bank_state_t state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (op_i)
      OP_BANK1_WR: begin
        state_d.nmi_en      = data_i[5];
        state_d.snd_bank_lo = {data_i[7:6], data_i[4]};
      end
      OP_BANK2_WR: state_d.snd_bank_hi = data_i[1:0];
      OP_GFXBK_WR: state_d.gfx_bank    = {data_i[7:6], data_i[1:0]};
      OP_ADRLO_WR: state_d.gfx_adr_lo  = data_i;
      OP_ADRHI_WR: state_d.gfx_adr_hi  = data_i;
      OP_COIN_WR: begin
        if (coin_tog_i) begin
          state_d.coin_flag = data_i[2] ? ~state_q.coin_flag : 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateRst;
    end else if (en_i) begin
      state_q <= state_d;
    end
  end

  assign state_o     = state_q;
  assign state_nxt_o = state_d;

endmodule

/* hw/rtl/rbag_addr_calc.sv */
// Sound and graphics ROM address forming, with the sound length check.
// Pure combinational logic. Depends on rbag_pkg.
module rbag_addr_calc import rbag_pkg::*; (
  input  op_e         op_i,
  input  logic [14:0] offset_i,
  input  bank_state_t state_i,
  input  logic [2:0]  snd_mode_i,
  input  logic [18:0] snd_bytes_i,
  output logic [21:0] rom_address_o,
  output logic        out_of_range_o
);

  logic [2:0]  snd_bank;
  logic [14:0] snd_off;
  logic [17:0] snd_adr;
  logic [21:0] gfx_adr;

  always_comb begin
    snd_off = offset_i;
    unique case (snd_mode_i)
      ModeBank2Bit0: snd_bank = {state_i.snd_bank_hi, state_i.snd_bank_lo[0]};
      ModeBit0:      snd_bank = {2'b00, state_i.snd_bank_lo[0]};
      ModeFull:      snd_bank = state_i.snd_bank_lo;
      ModeSwapHalf: begin
        snd_bank = {1'b0, state_i.snd_bank_lo[2:1]};
        snd_off  = {offset_i[6:0], offset_i[7], offset_i[14:8]};
      end
      default:       snd_bank = {1'b0, state_i.snd_bank_lo[2:1]};
    endcase
  end

  // bank steps are 32 KiB and the offset is below that, so the add is a join
  assign snd_adr = {snd_bank, snd_off};
  assign gfx_adr = {state_i.snd_bank_lo[1], state_i.gfx_bank, state_i.gfx_adr_hi,
                    state_i.gfx_adr_lo, offset_i[0]};

  always_comb begin
    rom_address_o  = '0;
    out_of_range_o = 1'b0;
    case (op_i)
      OP_SND_RD: begin
        rom_address_o  = {4'b0000, snd_adr};
        out_of_range_o = ({1'b0, snd_adr} >= snd_bytes_i);
      end
      OP_GFX_RD: rom_address_o = gfx_adr;
      default: ;
    endcase
  end

endmodule

/* hw/rtl/rom_bank_address_generator.sv */
// Top level of the ROM bank address generator.
// Instantiates rbag_bank_regs and rbag_addr_calc. Depends on rbag_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one bus operation:
//   op_i, data_i, offset_i. Register writes update the bank registers; sound
//   and graphics reads form a ROM byte address. Each transfer gives exactly
//   one result on the output channel (out_valid_o / out_stall_i): rom_address_o,
//   out_of_range_o and the NMI enable and coin-out flag as left by the item.
//   A result is valid in the cycle after its input transfer. Throughput is
//   one item per cycle unless the receiver stalls; the single result register
//   is refilled in the same cycle that its contents are taken.
//   While the receiver stalls with a result held, in_stall_o is raised and
//   the result holds steady.
//   Configuration (cfg_valid_i / cfg_ready_o, always ready) sets the sound
//   bank rule, the sound ROM length and the coin toggle enable; index 3 is
//   ignored. Write it only while the block is idle.
//   Reset: bank registers clear, coin-out flag set, bank rule 4, length
//   256 KiB, coin toggling off, output empty.
module rom_bank_address_generator import rbag_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [7:0]  data_i,
  input  logic [14:0] offset_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [21:0] rom_address_o,
  output logic        out_of_range_o,
  output logic        nmi_enabled_o,
  output logic        coin_out_flag_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [18:0] cfg_data_i
);

  logic [2:0]  snd_mode_q;
  logic [18:0] snd_bytes_q;
  logic        coin_tog_q;

  logic        in_acc;
  op_e         op;
  bank_state_t state, state_nxt;
  logic [21:0] adr;
  logic        oor;

  logic        out_valid_q;
  logic [21:0] rom_address_q;
  logic        out_of_range_q, nmi_q, coin_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snd_mode_q  <= SndModeRst;
      snd_bytes_q <= SndBytesRst;
      coin_tog_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgSndMode:  snd_mode_q  <= cfg_data_i[2:0];
        CfgSndBytes: snd_bytes_q <= cfg_data_i;
        CfgCoinTog:  coin_tog_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign op         = op_e'(op_i);

  rbag_bank_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (in_acc),
    .op_i        (op),
    .data_i      (data_i),
    .coin_tog_i  (coin_tog_q),
    .state_o     (state),
    .state_nxt_o (state_nxt)
  );

  rbag_addr_calc u_calc (
    .op_i           (op),
    .offset_i       (offset_i),
    .state_i        (state),
    .snd_mode_i     (snd_mode_q),
    .snd_bytes_i    (snd_bytes_q),
    .rom_address_o  (adr),
    .out_of_range_o (oor)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rom_address_q  <= adr;
      out_of_range_q <= oor;
      nmi_q          <= state_nxt.nmi_en;
      coin_q         <= state_nxt.coin_flag;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign rom_address_o   = rom_address_q;
  assign out_of_range_o  = out_of_range_q;
  assign nmi_enabled_o   = nmi_q;
  assign coin_out_flag_o = coin_q;

`ifndef ASSERT_OFF
  // every input transfer leaves a result waiting
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("no result after input transfer");

  // register writes give a zero address and no range flag
  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op_i != OP_SND_RD && op_i != OP_GFX_RD)
      |=> (rom_address_o == 22'd0 && !out_of_range_o))
    else $error("write result not zero");

  // only sound reads are flagged, and those stay within 18 bits
  a_oor_sound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |-> (rom_address_o[21:18] == 4'd0))
    else $error("range flag on wide address");
`endif

endmodule
